[hdl/ccp_pkg.sv]
// Shared constants and types for the contour colormap pixel pipeline.
// No dependencies.
`default_nettype none

package ccp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LEVEL_W       = 17;
    localparam int IN_TDATA_W    = 56;
    localparam int PIXEL_W       = 32;
    localparam logic [7:0] ALPHA_BYTE = 8'hFF;

    // Per-stage load enables, stage 1 is nearest the input.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

endpackage

`default_nettype wire

[hdl/ccp_ctrl.sv]
// Valid tracking and stall control for the six-stage pixel pipeline.
// Depends on ccp_pkg.
`default_nettype none

module ccp_ctrl
    import ccp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output stage_en_t      en
);

    logic [5:0] valid_reg;
    logic [5:0] valid_next;

    // A stage loads when it is empty or the stage after it moves.
    always_comb
    begin
        en.s6 = !valid_reg[5] || out_ready;
        en.s5 = !valid_reg[4] || en.s6;
        en.s4 = !valid_reg[3] || en.s5;
        en.s3 = !valid_reg[2] || en.s4;
        en.s2 = !valid_reg[1] || en.s3;
        en.s1 = !valid_reg[0] || en.s2;
    end

    always_comb
    begin
        valid_next[0] = en.s1 ? in_valid     : valid_reg[0];
        valid_next[1] = en.s2 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = en.s3 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = en.s4 ? valid_reg[2] : valid_reg[3];
        valid_next[4] = en.s5 ? valid_reg[3] : valid_reg[4];
        valid_next[5] = en.s6 ? valid_reg[4] : valid_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en.s1;
    assign out_valid = valid_reg[5];

endmodule

`default_nettype wire

[hdl/ccp_term.sv]
// Contour term (4*s*(1.01-s))^4 for one channel over stages 1 to 4.
// Depends on ccp_pkg.
`default_nettype none

module ccp_term
    import ccp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire stage_en_t            en,
    input  wire logic [LEVEL_W-1:0]   level,
    output logic      [FRAC_BITS:0]   term
);

    localparam int FW  = FRAC_BITS + 1;
    localparam int PW  = 2 * FW;
    localparam int UW  = FRAC_BITS + 2;
    localparam int SW  = (LEVEL_W > FW) ? LEVEL_W : FW;
    localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] K101 = (64'd101 * ONE + 64'd50) / 64'd100;

    logic [SW-1:0]   lvl_ext;
    logic [FW-1:0]   s_next;
    logic [FW-1:0]   s_reg;
    logic [FW-1:0]   d_reg;
    logic [PW-1:0]   prod_reg;
    logic [FW-1:0]   t_val;
    logic [PW-1:0]   tsq_reg;
    logic [UW-1:0]   u_val;
    logic [2*UW-1:0] usq_reg;
    logic [UW-1:0]   v_val;

    always_comb
    begin
        lvl_ext = SW'(level);
        s_next  = (lvl_ext > SW'(ONE)) ? FW'(ONE) : FW'(lvl_ext);
        t_val   = FW'(prod_reg >> (FRAC_BITS - 2));
        u_val   = UW'(tsq_reg >> FRAC_BITS);
        v_val   = UW'(usq_reg >> FRAC_BITS);
        term    = (v_val > UW'(ONE)) ? FW'(ONE) : FW'(v_val);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s_reg <= s_next;
            d_reg <= FW'(K101) - s_next;
        end
        if (en.s2)
        begin
            prod_reg <= PW'(s_reg) * PW'(d_reg);
        end
        if (en.s3)
        begin
            tsq_reg <= PW'(t_val) * PW'(t_val);
        end
        if (en.s4)
        begin
            usq_reg <= (2*UW)'(u_val) * (2*UW)'(u_val);
        end
    end

endmodule

`default_nettype wire

[hdl/ccp_mix.sv]
// Color mixing of three contour terms and byte scaling, stages 5 and 6.
// Depends on ccp_pkg.
`default_nettype none

module ccp_mix
    import ccp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire stage_en_t            en,
    input  wire logic [FRAC_BITS:0]   c0,
    input  wire logic [FRAC_BITS:0]   c1,
    input  wire logic [FRAC_BITS:0]   c2,
    output logic      [PIXEL_W-1:0]   pixel
);

    localparam int CW   = FRAC_BITS + 1;
    localparam int SUMW = FRAC_BITS + 3;
    localparam int XW   = FRAC_BITS + 9;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    logic [CW:0]          sum12;
    logic [CW-1:0]        half12;
    logic [SUMW-1:0]      gsum;
    logic [SUMW-1:0]      ghalf;
    logic [CW-1:0]        max01;
    logic [CW-1:0]        red_next;
    logic [CW-1:0]        green_next;
    logic [CW-1:0]        blue_next;
    logic [CW-1:0]        red_reg;
    logic [CW-1:0]        green_reg;
    logic [CW-1:0]        blue_reg;
    logic [XW-1:0]        red_x;
    logic [XW-1:0]        green_x;
    logic [XW-1:0]        blue_x;
    logic [PIXEL_W-1:0]   pixel_reg;

    always_comb
    begin
        sum12      = (CW+1)'(c1) + (CW+1)'(c2);
        half12     = CW'(sum12 >> 1);
        red_next   = (c0 < half12) ? c0 : half12;
        gsum       = SUMW'(c0) + SUMW'(c1) + SUMW'(c2);
        ghalf      = gsum >> 1;
        green_next = (ghalf > SUMW'(ONE)) ? CW'(ONE) : CW'(ghalf);
        max01      = (c1 > c0) ? c1 : c0;
        blue_next  = (c2 > max01) ? c2 : max01;
    end

    // x * 255 as (x << 8) - x
    always_comb
    begin
        red_x   = (XW'(red_reg)   << 8) - XW'(red_reg);
        green_x = (XW'(green_reg) << 8) - XW'(green_reg);
        blue_x  = (XW'(blue_reg)  << 8) - XW'(blue_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
        if (en.s6)
        begin
            pixel_reg <= {ALPHA_BYTE, red_x[FRAC_BITS+7:FRAC_BITS],
                          green_x[FRAC_BITS+7:FRAC_BITS], blue_x[FRAC_BITS+7:FRAC_BITS]};
        end
    end

    assign pixel = pixel_reg;

endmodule

`default_nettype wire

[hdl/contour_colormap_pixel.sv]
// Throughput: one pixel per cycle while m_tready is high; each stage holds when
// full and the next is stalled, so empty stages keep taking requests while an
// output waits.
// Reset (rst_n low, asynchronous) clears all stage valid bits; no clearing pass.
// Top level; depends on ccp_pkg, ccp_ctrl, ccp_term and ccp_mix.
`default_nettype none

module contour_colormap_pixel
    import ccp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // chan0_level [16:0], chan1_level [33:17], chan2_level [50:34], zero fill
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // packed_pixel [31:0]
    output logic      [PIXEL_W-1:0]      m_tdata
);

    stage_en_t          en;
    logic [FRAC_BITS:0] c0;
    logic [FRAC_BITS:0] c1;
    logic [FRAC_BITS:0] c2;

    ccp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .en        (en)
    );

    ccp_term #(.FRAC_BITS(FRAC_BITS)) u_term0 (
        .clk   (clk),
        .en    (en),
        .level (s_tdata[LEVEL_W-1:0]),
        .term  (c0)
    );

    ccp_term #(.FRAC_BITS(FRAC_BITS)) u_term1 (
        .clk   (clk),
        .en    (en),
        .level (s_tdata[2*LEVEL_W-1:LEVEL_W]),
        .term  (c1)
    );

    ccp_term #(.FRAC_BITS(FRAC_BITS)) u_term2 (
        .clk   (clk),
        .en    (en),
        .level (s_tdata[3*LEVEL_W-1:2*LEVEL_W]),
        .term  (c2)
    );

    ccp_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .clk   (clk),
        .en    (en),
        .c0    (c0),
        .c1    (c1),
        .c2    (c2),
        .pixel (m_tdata)
    );

endmodule

`default_nettype wire

[hdl/ccp_checker.sv]
// Port-level checks for contour_colormap_pixel, bound to the top level.
// Depends on ccp_pkg.
`default_nettype none

module ccp_checker
    import ccp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [PIXEL_W-1:0]      m_tdata
);

    // held output request keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output request changed while stalled");

    // an empty output stage never back-pressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:24] == ALPHA_BYTE)
        else $error("alpha byte wrong");

    // red is bounded by c0, blue by the max term
    a_red_le_blue: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:16] <= m_tdata[7:0])
        else $error("red above blue");

endmodule

bind contour_colormap_pixel ccp_checker u_ccp_checker (.*);

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for contour_colormap_pixel: a local predictor computes the BGRA word
// for each accepted request and compares it with every pixel the block returns.
// Depends on ccp_pkg and the contour_colormap_pixel RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccp_pkg::*;

    localparam int          FRAC       = FRAC_BITS_DEF;
    localparam logic [63:0] FX_ONE     = 64'd1 << FRAC;
    localparam logic [63:0] FX_K101    = (64'd101 * FX_ONE + 64'd50) / 64'd100;
    localparam logic [16:0] LEVEL_ONE  = 17'(FX_ONE);
    localparam logic [16:0] LEVEL_PEAK = 17'(FX_K101 / 2);
    localparam logic [16:0] LEVEL_MAX  = 17'h1FFFF;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIXEL_W-1:0]    m_tdata;

    logic [PIXEL_W-1:0] expected_pixels[$];
    int                 mismatch_count = 0;
    int                 pixels_checked = 0;
    int                 burst_left     = 0;
    bit                 sender_idles   = 1'b0;

    int unsigned        stall_cycle    = 0;
    int                 hold_left      = 0;
    logic               ready_level    = 1'b1;

    contour_colormap_pixel #(.FRAC_BITS(FRAC)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // contour term (4*s*(1.01-s))^4 in Q.FRAC, level saturated to 1.0, result limited to 1.0
    function automatic logic [63:0] contour_level_term(input logic [16:0] level);
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] v;
        s = 64'(level);
        if (s > FX_ONE)
            s = FX_ONE;
        t = (64'd4 * s * (FX_K101 - s)) >> FRAC;
        u = (t * t) >> FRAC;
        v = (u * u) >> FRAC;
        if (v > FX_ONE)
            v = FX_ONE;
        return v;
    endfunction

    function automatic logic [7:0] level_to_byte(input logic [63:0] x);
        logic [63:0] scaled;
        scaled = (x * 64'd255) >> FRAC;
        return scaled[7:0];
    endfunction

    function automatic logic [PIXEL_W-1:0] pixel_color_word(input logic [IN_TDATA_W-1:0] req);
        logic [63:0] c0;
        logic [63:0] c1;
        logic [63:0] c2;
        logic [63:0] half12;
        logic [63:0] red;
        logic [63:0] green;
        logic [63:0] blue;
        c0     = contour_level_term(req[16:0]);
        c1     = contour_level_term(req[33:17]);
        c2     = contour_level_term(req[50:34]);
        half12 = (c1 + c2) >> 1;
        red    = (c0 < half12) ? c0 : half12;
        green  = (c0 + c1 + c2) >> 1;
        if (green > FX_ONE)
            green = FX_ONE;
        blue = c0;
        if (c1 > blue)
            blue = c1;
        if (c2 > blue)
            blue = c2;
        return {ALPHA_BYTE, level_to_byte(red), level_to_byte(green), level_to_byte(blue)};
    endfunction

    task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] exp_word,
                                   input logic [PIXEL_W-1:0] got_word);
        $display("MISMATCH %s at %0t: expected %08h got %08h", what, $realtime, exp_word,
                 got_word);
        mismatch_count++;
    endtask

    // request monitor and pixel checker, both sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected pixel", '0, m_tdata);
                else if (m_tdata !== expected_pixels[0])
                    report_mismatch("packed_pixel", expected_pixels[0], m_tdata);
                if (expected_pixels.size() != 0)
                    void'(expected_pixels.pop_front());
                pixels_checked++;
            end
            if (s_tvalid && s_tready)
                expected_pixels.push_back(pixel_color_word(s_tdata));
        end
    end

    // receiver stall pattern: always ready, random, one in four, long on/off runs
    always @(posedge clk)
    begin
        stall_cycle++;
        case (stall_cycle[8:7])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (stall_cycle[1:0] == 2'd0);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_left   = $urandom_range(0, 12);
                    ready_level = !ready_level;
                end
                else
                    hold_left--;
                m_tready <= ready_level;
            end
        endcase
    end

    task automatic send_pixel(input logic [16:0] lvl0, input logic [16:0] lvl1,
                              input logic [16:0] lvl2);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_idles ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({lvl2, lvl1, lvl0});
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [16:0] random_level();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 17'($urandom_range(0, 32'(LEVEL_ONE)));
        else if (pick == 6)
            return 17'($urandom_range(0, 40));
        else if (pick == 7)
            return 17'($urandom_range(32'(LEVEL_ONE) - 40, 32'(LEVEL_ONE)));
        else if (pick == 8)
            return 17'($urandom_range(32'(LEVEL_PEAK) - 4000, 32'(LEVEL_PEAK) + 4000));
        return 17'($urandom_range(0, 32'(LEVEL_MAX)));
    endfunction

    task automatic test_directed_levels();
        sender_idles = 1'b0;
        send_pixel('0, '0, '0);
        send_pixel(LEVEL_ONE, LEVEL_ONE, LEVEL_ONE);
        send_pixel(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        send_pixel(LEVEL_ONE + 17'd1, LEVEL_ONE + 17'd1, LEVEL_ONE + 17'd1);
        send_pixel(LEVEL_ONE - 17'd1, 17'd1, LEVEL_ONE);
        send_pixel(17'd1, 17'd1, 17'd1);
        send_pixel(LEVEL_PEAK, LEVEL_PEAK, LEVEL_PEAK);
        send_pixel(LEVEL_PEAK, '0, '0);
        send_pixel('0, LEVEL_PEAK, '0);
        send_pixel('0, '0, LEVEL_PEAK);
        send_pixel('0, LEVEL_PEAK, LEVEL_PEAK);
        send_pixel(LEVEL_PEAK, LEVEL_PEAK, '0);
        send_pixel(17'h15555, 17'h0AAAA, LEVEL_MAX);
        send_pixel(17'h0AAAA, 17'h15555, '0);
        send_pixel(LEVEL_ONE / 2, LEVEL_ONE / 2, LEVEL_ONE / 2);
        send_pixel(LEVEL_ONE / 4, LEVEL_ONE / 2, 17'h0C000);
        send_pixel(LEVEL_MAX, '0, LEVEL_PEAK);
        send_pixel(LEVEL_PEAK - 17'd2000, LEVEL_PEAK + 17'd2000, 17'h1A5A5);
        drain_results();
    endtask

    task automatic test_random_pixels(input int count);
        sender_idles = 1'b1;
        repeat (count)
            send_pixel(random_level(), random_level(), random_level());
        drain_results();
    endtask

    // mix of over-range and random levels; over-range levels must saturate to exactly 1.0
    task automatic test_saturated_levels(input int count);
        logic [16:0] lvl[3];
        sender_idles = 1'b1;
        repeat (count)
        begin
            foreach (lvl[i])
                lvl[i] = $urandom_range(0, 1) ? 17'($urandom_range(32'(LEVEL_ONE),
                                                                   32'(LEVEL_MAX)))
                                              : random_level();
            send_pixel(lvl[0], lvl[1], lvl[2]);
        end
        drain_results();
    endtask

    // levels around the contour peak, where the term can exceed one and is limited
    task automatic test_contour_peak(input int count);
        logic [16:0] lvl[3];
        sender_idles = 1'b1;
        repeat (count)
        begin
            foreach (lvl[i])
                lvl[i] = 17'($urandom_range(32'(LEVEL_PEAK) - 6000, 32'(LEVEL_PEAK) + 6000));
            send_pixel(lvl[0], lvl[1], lvl[2]);
        end
        drain_results();
    endtask

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_levels();
        test_random_pixels(700);
        test_saturated_levels(200);
        test_contour_peak(150);

        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d pixels over extreme, in-range, over-range and contour-peak levels",
                 pixels_checked);
        $display("with sender bursts and receiver stalls; %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
